>>> design/tscc_pkg.sv
// Package for the typed scalar convert/compare block: type codes, opcodes, helpers.
// No dependencies.
`default_nettype none
package tscc_pkg;

  localparam int unsigned OpW   = 3;
  localparam int unsigned TypeW = 4;
  localparam int unsigned ValW  = 64;

  localparam logic [OpW-1:0] OP_CONVERT = 3'd0;
  localparam logic [OpW-1:0] OP_EQ      = 3'd1;
  localparam logic [OpW-1:0] OP_NE      = 3'd2;
  localparam logic [OpW-1:0] OP_GT      = 3'd3;
  localparam logic [OpW-1:0] OP_LT      = 3'd4;
  localparam logic [OpW-1:0] OP_GE      = 3'd5;
  localparam logic [OpW-1:0] OP_LE      = 3'd6;
  localparam logic [OpW-1:0] OP_NONE    = 3'd7;

  localparam logic [TypeW-1:0] TY_U8  = 4'd0;
  localparam logic [TypeW-1:0] TY_U16 = 4'd1;
  localparam logic [TypeW-1:0] TY_U32 = 4'd2;
  localparam logic [TypeW-1:0] TY_U64 = 4'd3;
  localparam logic [TypeW-1:0] TY_S8  = 4'd4;
  localparam logic [TypeW-1:0] TY_S16 = 4'd5;
  localparam logic [TypeW-1:0] TY_S32 = 4'd6;
  localparam logic [TypeW-1:0] TY_S64 = 4'd7;
  localparam logic [TypeW-1:0] TY_F32 = 4'd8;
  localparam logic [TypeW-1:0] TY_F64 = 4'd9;

  // Mask of a type's width.
  function automatic logic [63:0] type_mask(input logic [TypeW-1:0] t);
    logic [63:0] m;
    begin
      case (t)
        TY_U8, TY_S8:   m = 64'hFF;
        TY_U16, TY_S16: m = 64'hFFFF;
        TY_U32, TY_S32, TY_F32: m = 64'hFFFF_FFFF;
        default:        m = '1;
      endcase
      return m;
    end
  endfunction

  function automatic logic is_sint(input logic [TypeW-1:0] t);
    return (t == TY_S8) || (t == TY_S16) || (t == TY_S32) || (t == TY_S64);
  endfunction

  function automatic logic is_uint(input logic [TypeW-1:0] t);
    return (t == TY_U8) || (t == TY_U16) || (t == TY_U32) || (t == TY_U64);
  endfunction

  // Sign bit of an integer value of the given type (zero for other types).
  function automatic logic int_sign(input logic [63:0] v, input logic [TypeW-1:0] t);
    logic s;
    begin
      case (t)
        TY_S8:   s = v[7];
        TY_S16:  s = v[15];
        TY_S32:  s = v[31];
        TY_S64:  s = v[63];
        default: s = 1'b0;
      endcase
      return s;
    end
  endfunction

endpackage
`default_nettype wire

>>> design/typed_scalar_convert_compare_top.sv
// Typed scalar convert/compare: four-stage pipeline, one item per cycle.
// Depends on tscc_pkg.
//
// Usage: an item (opcode, two tagged 64-bit operands) enters on the in channel
// (in_valid_i/in_ready_o); one result item (result_value, compare_true,
// bad_type) leaves on the out channel (out_valid_o/out_ready_i).
// An accepted item passes the four register stages in order (decode to
// sign/exponent/mantissa, normalize, rounding and compare, saturate into the
// output register). Throughput: one item per cycle unless the receiver stalls.
// The pipeline advances as a whole when the output register is empty or
// being taken; a stalled receiver freezes every stage, so nothing is lost
// or repeated, and in_ready_o drops whenever a result item waits unaccepted,
// even with empty stages behind it.
// Reset clears every stage valid bit; payload registers are not reset.
// Every operand is first unpacked to sign, exponent and 64-bit mantissa;
// float inputs at or beyond 2^64 are flagged as huge and saturate.
// Ordered compares round integer operands to float64 precision first.
// Equal-type equality compares raw masked bits.
`default_nettype none
module typed_scalar_convert_compare_top (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      in_valid_i,
  output logic                           in_ready_o,
  input  wire logic [tscc_pkg::OpW-1:0]  opcode_i,
  input  wire logic [63:0]               first_value_i,
  input  wire logic [tscc_pkg::TypeW-1:0] first_type_i,
  input  wire logic [63:0]               second_value_i,
  input  wire logic [tscc_pkg::TypeW-1:0] second_type_i,
  output logic                           out_valid_o,
  input  wire logic                      out_ready_i,
  output logic [63:0]                    result_value_o,
  output logic                           compare_true_o,
  output logic                           bad_type_o
);
  import tscc_pkg::*;

  // Operand in canonical form: NaN, inf, zero, sign, and magnitude as float
  // exponent + normalized 64-bit mantissa, which holds any integer exactly.
  // Values with exponent >= 64 are "huge".
  typedef struct packed {
    logic        nan;
    logic        inf;
    logic        zero;
    logic        sign;
    logic signed [12:0] exp;  // value = 1.man * 2^exp (man[63] is hidden one)
    logic [63:0] man;         // normalized, man[63]=1 unless zero
  } norm_t;

  logic adv;

  // ---------------- stage 1: decode operands to sign/exp/raw mantissa -----
  typedef struct packed {
    logic        nan;
    logic        inf;
    logic        sign;
    logic signed [12:0] exp;  // exponent of bit 63 of raw mantissa
    logic [63:0] man;         // un-normalized mantissa
  } raw_t;

  function automatic raw_t decode(input logic [63:0] v, input logic [TypeW-1:0] t);
    raw_t r;
    logic [63:0] m;
    logic s;
    begin
      r = '0;
      m = v & type_mask(t);
      if (t == TY_F32) begin
        r.sign = v[31];
        r.nan  = (v[30:23] == 8'hFF) && (v[22:0] != '0);
        r.inf  = (v[30:23] == 8'hFF) && (v[22:0] == '0);
        if (v[30:23] == 8'h00) begin
          r.man = {1'b0, v[22:0], 40'd0};
          r.exp = -13'sd126;
        end else begin
          r.man = {1'b1, v[22:0], 40'd0};
          r.exp = $signed({5'd0, v[30:23]}) - 13'sd127;
        end
      end else if (t == TY_F64) begin
        r.sign = v[63];
        r.nan  = (v[62:52] == 11'h7FF) && (v[51:0] != '0);
        r.inf  = (v[62:52] == 11'h7FF) && (v[51:0] == '0);
        if (v[62:52] == 11'h000) begin
          r.man = {1'b0, v[51:0], 11'd0};
          r.exp = -13'sd1022;
        end else begin
          r.man = {1'b1, v[51:0], 11'd0};
          r.exp = $signed({2'd0, v[62:52]}) - 13'sd1023;
        end
      end else begin
        s = int_sign(v, t);
        r.sign = s;
        r.man  = s ? ((~m + 64'd1) & type_mask(t)) : m;
        if (s && t == TY_S64) r.man = ~v + 64'd1;
        r.exp  = 13'sd63;
      end
      return r;
    end
  endfunction

  typedef struct packed {
    logic [OpW-1:0]   op;
    logic [TypeW-1:0] ta;
    logic [TypeW-1:0] tb;
    logic [63:0]      am;   // masked raw first
    logic             bad;
    logic             rawcmp;
    logic             raweq;
    raw_t             a;
    raw_t             b;
  } s1_t;

  s1_t s1_d, s1_q;
  logic v1_q, v2_q, v3_q, v4_q;

  always_comb begin
    s1_d.op  = opcode_i;
    s1_d.ta  = first_type_i;
    s1_d.tb  = second_type_i;
    s1_d.am  = first_value_i & type_mask(first_type_i);
    s1_d.bad = (first_type_i > TY_F64) || (second_type_i > TY_F64);
    s1_d.rawcmp = (first_type_i == second_type_i) &&
                  ((opcode_i == OP_EQ) || (opcode_i == OP_NE));
    s1_d.raweq = ((first_value_i ^ second_value_i) & type_mask(first_type_i)) == '0;
    s1_d.a = decode(first_value_i, first_type_i);
    s1_d.b = decode(second_value_i, second_type_i);
  end

  // ---------------- stage 2: normalize (leading-zero count) -----------------
  function automatic norm_t normalize(input raw_t r);
    norm_t n;
    logic [5:0] lz;
    begin
      lz = '0;
      for (int i = 0; i < 64; i++) begin
        if (r.man[i]) lz = 6'(63 - i);
      end
      n.nan  = r.nan;
      n.inf  = r.inf;
      n.sign = r.sign;
      n.zero = (r.man == '0) && !r.nan && !r.inf;
      n.man  = r.man << lz;
      n.exp  = r.exp - $signed({7'd0, lz});
      return n;
    end
  endfunction

  typedef struct packed {
    logic [OpW-1:0]   op;
    logic [TypeW-1:0] ta;
    logic [TypeW-1:0] tb;
    logic [63:0]      am;
    logic             bad;
    logic             rawcmp;
    logic             raweq;
    norm_t            a;
    norm_t            b;
  } s2_t;

  s2_t s2_d, s2_q;

  always_comb begin
    s2_d.op = s1_q.op;  s2_d.ta = s1_q.ta;  s2_d.tb = s1_q.tb;
    s2_d.am = s1_q.am;  s2_d.bad = s1_q.bad;
    s2_d.rawcmp = s1_q.rawcmp;  s2_d.raweq = s1_q.raweq;
    s2_d.a = normalize(s1_q.a);
    s2_d.b = normalize(s1_q.b);
  end

  // ---------------- stage 3: integer part / rounding / compare -------------
  typedef struct packed {
    logic [OpW-1:0]   op;
    logic [TypeW-1:0] tb;
    logic             bad;
    logic             same;
    logic [63:0]      am;
    logic             nan;
    logic             sign;
    logic             zero;
    logic             huge;     // magnitude >= 2^64 (or inf)
    logic [63:0]      ival;     // truncated integer magnitude
    logic [63:0]      fbits;    // float target bits
    logic             cmp;
  } s3_t;

  s3_t s3_d, s3_q;

  // Round normalized mantissa to p significant bits (RNE) and pack.
  function automatic logic [63:0] pack_float(input norm_t n, input logic dbl);
    logic [63:0] out;
    int unsigned p;
    int signed  emin, emax, bias, e, sh;
    logic [127:0] ext;
    logic [63:0] kept;
    logic g, st, lsb;
    logic [64:0] rnd;
    logic signed [13:0] eo;
    begin
      p    = dbl ? 53 : 24;
      emin = dbl ? -1022 : -126;
      emax = dbl ? 1023 : 127;
      bias = dbl ? 1023 : 127;
      e    = int'(n.exp);
      // bits to drop from the 64-bit mantissa
      sh = 64 - int'(p);
      if (e < emin) sh = sh + (emin - e);
      if (sh > 66) sh = 66;
      ext  = {n.man, 64'd0} >> sh;
      kept = ext[127:64];
      g    = ext[63];
      st   = (ext[62:0] != '0);
      lsb  = kept[0];
      rnd  = {1'b0, kept} + 65'(g && (st || lsb));
      eo   = (e < emin) ? 14'(emin) : 14'(e);
      if (rnd[p]) begin
        rnd = rnd >> 1;
        eo  = eo + 14'sd1;
      end
      out = '0;
      if (n.nan) begin
        // quiet the NaN and keep the top of its payload
        out = dbl ? {n.sign, 11'h7FF, 1'b1, n.man[61:11]}
                  : {32'd0, n.sign, 8'hFF, 1'b1, n.man[61:40]};
      end else if (n.zero) begin
        out = dbl ? {n.sign, 63'd0} : {32'd0, n.sign, 31'd0};
      end else if (n.inf || eo > 14'(emax)) begin
        out = dbl ? {n.sign, 11'h7FF, 52'd0} : {32'd0, n.sign, 8'hFF, 23'd0};
      end else if (!rnd[p-1]) begin
        // subnormal (exponent field zero)
        out = dbl ? {n.sign, 11'd0, rnd[51:0]} : {32'd0, n.sign, 8'd0, rnd[22:0]};
      end else begin
        out = dbl ? {n.sign, 11'(eo + 14'(bias)), rnd[51:0]}
                  : {32'd0, n.sign, 8'(eo + 14'(bias)), rnd[22:0]};
      end
      return out;
    end
  endfunction

  // Round a normalized mantissa to float64 precision (RNE).
  function automatic norm_t round53(input norm_t n);
    norm_t r;
    logic [53:0] k;
    logic inc;
    begin
      r   = n;
      inc = n.man[10] && ((n.man[9:0] != '0) || n.man[11]);
      k   = {1'b0, n.man[63:11]} + 54'(inc);
      if (k[53]) begin
        r.man = {1'b1, 63'd0};
        r.exp = n.exp + 13'sd1;
      end else begin
        r.man = {k[52:0], 11'd0};
      end
      return r;
    end
  endfunction

  // Signed magnitude compare: returns {lt, eq}.
  function automatic logic [1:0] fcmp(input norm_t a, input norm_t b);
    logic mlt, meq;
    logic lt, eq;
    begin
      if (a.inf || b.inf) begin
        meq = a.inf && b.inf;
        mlt = b.inf && !a.inf;
      end else if (a.zero || b.zero) begin
        meq = a.zero && b.zero;
        mlt = a.zero && !b.zero;
      end else begin
        meq = (a.exp == b.exp) && (a.man == b.man);
        mlt = (a.exp < b.exp) || ((a.exp == b.exp) && (a.man < b.man));
      end
      if (a.zero && b.zero) begin
        eq = 1'b1; lt = 1'b0;
      end else if (a.sign != b.sign) begin
        eq = 1'b0; lt = a.sign;
      end else begin
        eq = meq; lt = a.sign ? (!mlt && !meq) : mlt;
      end
      return {lt, eq};
    end
  endfunction

  always_comb begin
    logic [1:0] le;
    logic lt, eq, un;
    logic [127:0] sh;
    int signed e;
    s3_d.op   = s2_q.op;
    s3_d.tb   = s2_q.tb;
    s3_d.bad  = s2_q.bad;
    s3_d.same = (s2_q.ta == s2_q.tb);
    s3_d.am   = s2_q.am;
    s3_d.nan  = s2_q.a.nan;
    s3_d.sign = s2_q.a.sign;
    s3_d.zero = s2_q.a.zero;
    e = int'(s2_q.a.exp);
    s3_d.huge = s2_q.a.inf || (!s2_q.a.zero && e >= 64);
    // integer part: man * 2^(e-63)
    if (s2_q.a.zero || e < 0) sh = '0;
    else if (e >= 64) sh = '0;
    else sh = {64'd0, s2_q.a.man} >> (63 - e);
    s3_d.ival = sh[63:0];
    s3_d.fbits = pack_float(s2_q.a, s2_q.tb == TY_F64);
    // compare both operands as float64 values
    le = fcmp(round53(s2_q.a), round53(s2_q.b));
    lt = le[1]; eq = le[0];
    un = s2_q.a.nan || s2_q.b.nan;
    if (s2_q.rawcmp) begin
      s3_d.cmp = (s2_q.op == OP_EQ) ? s2_q.raweq : !s2_q.raweq;
    end else begin
      case (s2_q.op)
        OP_EQ:   s3_d.cmp = !un && eq;
        OP_NE:   s3_d.cmp = un || !eq;
        OP_GT:   s3_d.cmp = !un && !lt && !eq;
        OP_LT:   s3_d.cmp = !un && lt;
        OP_GE:   s3_d.cmp = !un && !lt;
        OP_LE:   s3_d.cmp = !un && (lt || eq);
        default: s3_d.cmp = 1'b0;
      endcase
    end
  end

  // ---------------- stage 4: saturate and select result ---------------------
  typedef struct packed {
    logic [63:0] res;
    logic        cmp;
    logic        bad;
  } s4_t;

  s4_t s4_d, s4_q;

  always_comb begin
    logic [63:0] lim, hi;
    logic [63:0] conv;
    lim  = type_mask(s3_q.tb);
    hi   = lim >> 1;
    conv = '0;
    if (s3_q.same) begin
      conv = s3_q.am;
    end else if (is_uint(s3_q.tb)) begin
      if (s3_q.nan || s3_q.sign) conv = '0;
      else if (s3_q.huge || s3_q.ival > lim) conv = lim;
      else conv = s3_q.ival;
    end else if (is_sint(s3_q.tb)) begin
      if (s3_q.nan || s3_q.zero) conv = '0;
      else if (!s3_q.sign) conv = (s3_q.huge || s3_q.ival > hi) ? hi : s3_q.ival;
      else if (s3_q.huge || s3_q.ival > hi + 64'd1) conv = (~hi) & lim;
      else conv = (~s3_q.ival + 64'd1) & lim;
    end else begin
      conv = s3_q.fbits;
    end
    s4_d.bad = 1'b0; s4_d.res = '0; s4_d.cmp = 1'b0;
    if (s3_q.op != OP_NONE) begin
      if (s3_q.bad) s4_d.bad = 1'b1;
      else if (s3_q.op == OP_CONVERT) s4_d.res = conv;
      else s4_d.cmp = s3_q.cmp;
    end
  end

  // ---------------- pipeline control ----------------------------------------
  // Advance all stages together when the output stage is free or being taken.
  assign adv        = !v4_q || out_ready_i;
  assign in_ready_o = adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0; v2_q <= 1'b0; v3_q <= 1'b0; v4_q <= 1'b0;
    end else if (adv) begin
      v1_q <= in_valid_i; v2_q <= v1_q; v3_q <= v2_q; v4_q <= v3_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s1_q <= s1_d; s2_q <= s2_d; s3_q <= s3_d; s4_q <= s4_d;
    end
  end

  assign out_valid_o    = v4_q;
  assign result_value_o = s4_q.res;
  assign compare_true_o = s4_q.cmp;
  assign bad_type_o     = s4_q.bad;

  // ---------------- assertions ----------------------------------------------
  a_bad_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && bad_type_o |-> (result_value_o == '0) && !compare_true_o)
    else $error("bad type item carries data");
  a_one_kind: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !(compare_true_o && (result_value_o != '0)))
    else $error("both compare and convert result set");
  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(result_value_o))
    else $error("output changed during stall");
  a_flow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> v1_q)
    else $error("accepted item lost at stage one");
endmodule
`default_nettype wire

>>> dv/tb_top.sv
// Self-checking bench for the typed scalar convert/compare block.
// Depends on tscc_pkg and typed_scalar_convert_compare_top; the expected values
// come from a float model that lives here.
`timescale 1ns / 1ps
module tb_top;
  import tscc_pkg::*;

  localparam int WatchLimit = 3000;
  localparam int HoldCycles = 300;

  typedef struct packed {
    logic [OpW-1:0]   op;
    logic [63:0]      a;
    logic [TypeW-1:0] ta;
    logic [63:0]      b;
    logic [TypeW-1:0] tb;
  } item_t;

  typedef struct packed {
    logic [63:0] value;
    logic        cmp;
    logic        bad;
  } result_t;

  // Operand as sign, integer significand and binary exponent.
  typedef struct {
    logic        nan;
    logic        inf;
    logic        s;
    logic [63:0] m;
    int          e;
  } num_t;

  logic clk_i;
  logic rst_ni;
  logic in_valid;
  logic in_ready_o;
  item_t cur;
  logic out_valid_o;
  logic out_ready;
  logic [63:0] result_value_o;
  logic compare_true_o;
  logic bad_type_o;

  item_t   pending_items[$];
  result_t results_due[$];
  int      err_count;
  int      gap_pct;
  int      stall_pct;
  logic    hold_req;
  logic    hold_done;
  int      hold_cnt;
  logic    hold_active;
  int      idle_cycles;

  typed_scalar_convert_compare_top DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid),
    .in_ready_o    (in_ready_o),
    .opcode_i      (cur.op),
    .first_value_i (cur.a),
    .first_type_i  (cur.ta),
    .second_value_i(cur.b),
    .second_type_i (cur.tb),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready),
    .result_value_o(result_value_o),
    .compare_true_o(compare_true_o),
    .bad_type_o    (bad_type_o)
  );

  // ---------------------------------------------------------------- model

  function automatic int width_of(logic [TypeW-1:0] t);
    case (t)
      TY_U8, TY_S8:           return 8;
      TY_U16, TY_S16:         return 16;
      TY_U32, TY_S32, TY_F32: return 32;
      default:                return 64;
    endcase
  endfunction

  function automatic logic [63:0] mask_of(logic [TypeW-1:0] t);
    int w;
    w = width_of(t);
    return (w == 64) ? '1 : ((64'd1 << w) - 64'd1);
  endfunction

  function automatic logic signed [63:0] sext(logic [63:0] v, int w);
    logic [63:0] x;
    x = v << (64 - w);
    return $signed(x) >>> (64 - w);
  endfunction

  function automatic int msb_of(logic [63:0] m);
    for (int i = 63; i >= 0; i--) if (m[i]) return i;
    return -1;
  endfunction

  // Round m * 2^e to float32 or float64 bits, nearest even, with subnormals
  // and overflow to infinity.
  function automatic logic [63:0] pack_float(logic s, logic [63:0] m, int e, bit to32);
    int F, bias, p, field, sh;
    logic [127:0] mm, keep, rem, half;
    logic [63:0] bits, inf_b;
    F = to32 ? 23 : 52;
    bias = to32 ? 127 : 1023;
    if (m == 0) return to32 ? {32'b0, s, 31'b0} : {s, 63'b0};
    p = msb_of(m);
    field = p + e + bias;
    sh = (field >= 1) ? p - F : (1 - bias - F) - e;
    mm = {64'b0, m};
    if (sh <= 0) begin
      keep = mm << (-sh);
    end else if (sh >= 80) begin
      keep = '0;
    end else begin
      keep = mm >> sh;
      rem  = mm - (keep << sh);
      half = 128'd1 << (sh - 1);
      if (rem > half || (rem == half && keep[0])) keep = keep + 1;
    end
    bits = ((field >= 1) ? (64'(field - 1) << F) : 64'd0) + keep[63:0];
    inf_b = to32 ? 64'h7F80_0000 : 64'h7FF0_0000_0000_0000;
    if (bits >= inf_b) bits = inf_b;
    return to32 ? {32'b0, s, bits[30:0]} : {s, bits[62:0]};
  endfunction

  function automatic num_t decode(logic [63:0] v, logic [TypeW-1:0] t);
    num_t n;
    logic signed [63:0] sv;
    n.nan = 0; n.inf = 0; n.s = 0; n.m = 0; n.e = 0;
    if (t == TY_F32) begin
      n.s = v[31];
      if (v[30:23] == 8'hFF) begin
        n.nan = v[22:0] != 0;
        n.inf = v[22:0] == 0;
      end else if (v[30:23] == 0) begin
        n.m = {41'b0, v[22:0]};
        n.e = -149;
      end else begin
        n.m = {40'b0, 1'b1, v[22:0]};
        n.e = int'(v[30:23]) - 150;
      end
    end else if (t == TY_F64) begin
      n.s = v[63];
      if (v[62:52] == 11'h7FF) begin
        n.nan = v[51:0] != 0;
        n.inf = v[51:0] == 0;
      end else if (v[62:52] == 0) begin
        n.m = {12'b0, v[51:0]};
        n.e = -1074;
      end else begin
        n.m = {11'b0, 1'b1, v[51:0]};
        n.e = int'(v[62:52]) - 1075;
      end
    end else if (is_sint(t)) begin
      sv = sext(v, width_of(t));
      n.s = sv[63];
      n.m = n.s ? -sv : sv;
    end else begin
      n.m = v & mask_of(t);
    end
    return n;
  endfunction

  // Value widened to float64 bits (quiets a float32 NaN, keeps its payload).
  function automatic logic [63:0] widen_f64(logic [63:0] v, logic [TypeW-1:0] t);
    num_t n;
    if (t == TY_F64) return v;
    n = decode(v, t);
    if (n.nan) return {n.s, 11'h7FF, 1'b1, v[21:0], 29'b0};
    if (n.inf) return {n.s, 11'h7FF, 52'b0};
    return pack_float(n.s, n.m, n.e, 1'b0);
  endfunction

  // Magnitude truncated toward zero; ovf set when it does not fit 64 bits.
  function automatic logic [63:0] trunc_mag(num_t n, output logic ovf);
    logic [127:0] t;
    ovf = n.inf;
    if (n.inf) return '1;
    if (n.e >= 64) begin
      ovf = n.m != 0;
      return '1;
    end
    if (n.e >= 0) begin
      t = {64'b0, n.m} << n.e;
      ovf = |t[127:64];
      return t[63:0];
    end
    if (-n.e >= 64) return '0;
    return n.m >> (-n.e);
  endfunction

  function automatic logic [63:0] sat_unsigned(logic [63:0] v, logic [TypeW-1:0] t);
    num_t n;
    logic ovf;
    logic [63:0] mg;
    logic signed [63:0] sv;
    if (t == TY_F32 || t == TY_F64) begin
      n = decode(v, t);
      if (n.nan || n.s) return '0;
      mg = trunc_mag(n, ovf);
      return ovf ? '1 : mg;
    end
    if (is_sint(t)) begin
      sv = sext(v, width_of(t));
      return sv[63] ? '0 : sv;
    end
    return v & mask_of(t);
  endfunction

  function automatic logic signed [63:0] sat_signed(logic [63:0] v, logic [TypeW-1:0] t);
    num_t n;
    logic ovf;
    logic [63:0] mg, u;
    if (t == TY_F32 || t == TY_F64) begin
      n = decode(v, t);
      if (n.nan) return '0;
      mg = trunc_mag(n, ovf);
      if (!n.s) return (ovf || mg[63]) ? 64'sh7FFF_FFFF_FFFF_FFFF : $signed(mg);
      if (ovf || mg >= 64'h8000_0000_0000_0000) return 64'sh8000_0000_0000_0000;
      return -$signed(mg);
    end
    if (is_sint(t)) return sext(v, width_of(t));
    u = v & mask_of(t);
    return u[63] ? 64'sh7FFF_FFFF_FFFF_FFFF : $signed(u);
  endfunction

  function automatic logic [63:0] convert_value(logic [63:0] v, logic [TypeW-1:0] from,
                                               logic [TypeW-1:0] to);
    logic [63:0] mask, u;
    logic signed [63:0] s, hi, lo;
    num_t n;
    mask = mask_of(to);
    if (from == to) return v & mask;
    if (is_uint(to)) begin
      u = sat_unsigned(v, from);
      return (u > mask) ? mask : u;
    end
    if (is_sint(to)) begin
      s  = sat_signed(v, from);
      hi = $signed(mask >> 1);
      lo = -hi - 1;
      if (s > hi) s = hi;
      if (s < lo) s = lo;
      return s & mask;
    end
    if (to == TY_F32) begin
      n = decode(v, from);
      if (n.nan) return {32'b0, n.s, 8'hFF, 1'b1, v[50:29]};
      if (n.inf) return {32'b0, n.s, 31'h7F80_0000};
      return pack_float(n.s, n.m, n.e, 1'b1);
    end
    return widen_f64(v, from);
  endfunction

  function automatic logic compare_values(item_t it);
    logic [63:0] xb, yb, m;
    real x, y;
    if (it.ta == it.tb && (it.op == OP_EQ || it.op == OP_NE)) begin
      m = mask_of(it.ta);
      return (it.op == OP_EQ) ? ((it.a & m) == (it.b & m)) : ((it.a & m) != (it.b & m));
    end
    xb = widen_f64(it.a, it.ta);
    yb = widen_f64(it.b, it.tb);
    // any NaN: only "not equal" holds
    if ((xb[62:52] == 11'h7FF && xb[51:0] != 0) || (yb[62:52] == 11'h7FF && yb[51:0] != 0))
      return it.op == OP_NE;
    x = $bitstoreal(xb);
    y = $bitstoreal(yb);
    case (it.op)
      OP_EQ:   return x == y;
      OP_NE:   return x != y;
      OP_GT:   return x > y;
      OP_LT:   return x < y;
      OP_GE:   return x >= y;
      default: return x <= y;
    endcase
  endfunction

  function automatic result_t predict_result(item_t it);
    result_t r;
    r = '0;
    if (it.op == OP_NONE) return r;
    if (it.ta > TY_F64 || it.tb > TY_F64) r.bad = 1'b1;
    else if (it.op == OP_CONVERT) r.value = convert_value(it.a, it.ta, it.tb);
    else r.cmp = compare_values(it);
    return r;
  endfunction

  // ---------------------------------------------------------------- stimulus

  function automatic logic [63:0] rand64();
    return {$urandom(), $urandom()};
  endfunction

  function automatic logic [63:0] rand_typed(logic [TypeW-1:0] t);
    logic [63:0] junk, p;
    int w;
    junk = ($urandom_range(0, 3) == 0) ? rand64() : 64'd0;
    w = width_of(t);
    if (t == TY_F64) begin
      case ($urandom_range(0, 19))
        0: p = 64'h0;                    1: p = 64'h8000_0000_0000_0000;
        2: p = 64'h7FF0_0000_0000_0000;  3: p = 64'hFFF0_0000_0000_0000;
        4: p = 64'h7FF8_0000_0000_0000;  5: p = 64'h7FF0_0000_0000_0001;
        6: p = 64'h0000_0000_0000_0001;  7: p = 64'h7FEF_FFFF_FFFF_FFFF;
        8: p = 64'h43E0_0000_0000_0000;  9: p = 64'hC3E0_0000_0000_0000;
        10: p = 64'h43F0_0000_0000_0000; 11: p = 64'h3FF0_0000_0000_0000;
        12: p = 64'hBFE0_0000_0000_0000; 13: p = 64'h47EF_FFFF_F000_0000;
        14: p = 64'h47EF_FFFF_E000_0000; 15: p = rand64();
        16: p = {1'b0, 11'(874 + $urandom_range(0, 30)), 52'(rand64())};
        default: p = {$urandom_range(0, 1) == 1, 11'(1013 + $urandom_range(0, 80)),
                      52'(rand64())};
      endcase
      return p;
    end
    if (t == TY_F32) begin
      case ($urandom_range(0, 15))
        0: p = 64'h0;            1: p = 64'h8000_0000;
        2: p = 64'h7F80_0000;    3: p = 64'hFF80_0000;
        4: p = 64'h7FC0_0000;    5: p = 64'h7F80_0001;
        6: p = 64'h0000_0001;    7: p = 64'h7F7F_FFFF;
        8: p = 64'h5F00_0000;    9: p = 64'hDF00_0000;
        10: p = 64'h5F80_0000;   11: p = 64'h3F80_0000;
        12: p = 64'h4F00_0000;   13: p = {32'b0, $urandom()};
        default: p = {32'b0, $urandom_range(0, 1) == 1, 8'(117 + $urandom_range(0, 80)),
                      23'($urandom())};
      endcase
      return (junk & ~mask_of(t)) | p;
    end
    case ($urandom_range(0, 7))
      0: p = 64'd0;
      1: p = '1;
      2: p = 64'd1 << (w - 1);
      3: p = (64'd1 << (w - 1)) - 64'd1;
      4: p = 64'($urandom_range(0, 300));
      default: p = rand64();
    endcase
    return (junk & ~mask_of(t)) | (p & mask_of(t));
  endfunction

  function automatic logic [TypeW-1:0] rand_type();
    return ($urandom_range(0, 29) == 0) ? TypeW'($urandom_range(10, 15))
                                        : TypeW'($urandom_range(0, 9));
  endfunction

  function automatic item_t rand_item();
    item_t it;
    it.op = ($urandom_range(0, 39) == 0) ? OP_NONE
          : ($urandom_range(0, 1) == 0) ? OP_CONVERT : OpW'($urandom_range(1, 6));
    it.ta = rand_type();
    it.tb = ($urandom_range(0, 4) == 0) ? it.ta : rand_type();
    it.a  = rand_typed(it.ta);
    it.b  = ($urandom_range(0, 3) == 0) ? it.a : rand_typed(it.tb);
    return it;
  endfunction

  task automatic add_item(logic [OpW-1:0] op, logic [63:0] a, logic [TypeW-1:0] ta,
                          logic [63:0] b, logic [TypeW-1:0] tb);
    pending_items.push_back('{op: op, a: a, ta: ta, b: b, tb: tb});
  endtask

  task automatic report_mismatch(string field, logic [63:0] got, logic [63:0] want);
    $display("[%0t] mismatch on %s: got %h, expected %h", $time, field, got, want);
    err_count++;
  endtask

  // ---------------------------------------------------------------- clock, reset

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // ---------------------------------------------------------------- driver
  // Record the accepted item, then offer the next one or a gap.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid <= 1'b0;
      cur      <= '0;
    end else begin
      if (in_valid && in_ready_o) results_due.push_back(predict_result(cur));
      if (!in_valid || in_ready_o) begin
        if (pending_items.size() > 0 && $urandom_range(0, 99) >= gap_pct) begin
          cur      <= pending_items.pop_front();
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------- monitor
  // Check each result item against the oldest prediction, then pick ready.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid_o && out_ready) begin
        if (results_due.size() == 0) begin
          report_mismatch("unexpected item", result_value_o, 64'd0);
        end else begin
          result_t want;
          want = results_due.pop_front();
          if (result_value_o !== want.value)
            report_mismatch("result_value", result_value_o, want.value);
          if (compare_true_o !== want.cmp)
            report_mismatch("compare_true", 64'(compare_true_o), 64'(want.cmp));
          if (bad_type_o !== want.bad)
            report_mismatch("bad_type", 64'(bad_type_o), 64'(want.bad));
        end
      end
      out_ready <= hold_active ? 1'b0 : ($urandom_range(0, 99) >= stall_pct);
    end
  end

  // Long receiver hold-off, counted here once requested.
  assign hold_active = hold_req && !hold_done;
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hold_cnt  <= 0;
      hold_done <= 1'b0;
    end else if (hold_active) begin
      hold_cnt <= hold_cnt + 1;
      if (hold_cnt == HoldCycles) hold_done <= 1'b1;
    end
  end

  // Watchdog: stop if neither channel moves for too long.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idle_cycles <= 0;
    end else begin
      if ((in_valid && in_ready_o) || (out_valid_o && out_ready)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles == WatchLimit) begin
        $display("DONE: errors detected");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------- sequence
  initial begin
    err_count = 0;
    gap_pct   = 0;
    stall_pct = 0;
    hold_req  = 1'b0;
    rst_ni    = 1'b0;
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed corners: saturation, NaN, signed zero, rounding, bad codes.
    add_item(OP_CONVERT, 64'h7FF8_0000_0000_0000, TY_F64, 64'd0, TY_U32);
    add_item(OP_CONVERT, 64'h43F0_0000_0000_0000, TY_F64, 64'd0, TY_U64);
    add_item(OP_CONVERT, 64'hC3E0_0000_0000_0000, TY_F64, 64'd0, TY_S64);
    add_item(OP_CONVERT, 64'hBFF8_0000_0000_0000, TY_F64, 64'd0, TY_U8);
    add_item(OP_CONVERT, 64'h80, TY_S8, 64'd0, TY_U8);
    add_item(OP_CONVERT, '1, TY_U64, 64'd0, TY_S64);
    add_item(OP_CONVERT, 64'h8000_0000_0000_0000, TY_S64, 64'd0, TY_S16);
    add_item(OP_CONVERT, '1, TY_U64, 64'd0, TY_F32);
    add_item(OP_CONVERT, 64'h47EF_FFFF_F000_0000, TY_F64, 64'd0, TY_F32);
    add_item(OP_CONVERT, 64'hC7EF_FFFF_E800_0000, TY_F64, 64'd0, TY_F32);
    add_item(OP_CONVERT, 64'h0000_0000_0000_0001, TY_F64, 64'd0, TY_F32);
    add_item(OP_CONVERT, 64'h7F80_0001, TY_F32, 64'd0, TY_F64);
    add_item(OP_CONVERT, 64'h8000_0000, TY_F32, 64'd0, TY_S32);
    add_item(OP_CONVERT, 64'hDEAD_BEEF_7FC0_1234, TY_F32, 64'd0, TY_F32);
    add_item(OP_CONVERT, 64'hFFFF_FFFF_FFFF_8000, TY_U16, 64'd0, TY_S16);
    add_item(OP_EQ, 64'h0, TY_F64, 64'h8000_0000_0000_0000, TY_F64);
    add_item(OP_EQ, 64'h0, TY_F64, 64'h8000_0000, TY_F32);
    add_item(OP_EQ, 64'h7FF8_0000_0000_0001, TY_F64, 64'h7FF8_0000_0000_0001, TY_F64);
    add_item(OP_NE, 64'h7FC0_0000, TY_F32, 64'h7FF8_0000_0000_0000, TY_F64);
    add_item(OP_GT, 64'hFF, TY_S8, 64'hFF, TY_U8);
    add_item(OP_LT, 64'hFF, TY_S8, 64'hFF, TY_U8);
    add_item(OP_GE, 64'h4000_0000_0000_0000, TY_F64, 64'h2, TY_S32);
    add_item(OP_LE, 64'hFF80_0000, TY_F32, 64'h8000_0000_0000_0000, TY_S64);
    add_item(OP_CONVERT, 64'd5, TY_U8, 64'd0, TypeW'(12));
    add_item(OP_NONE, 64'd5, TypeW'(15), 64'd1, TY_U8);

    // Phase 1: no gaps, long receiver hold so the pipeline fills and stalls.
    @(negedge clk_i);
    hold_req = 1'b1;
    repeat (383) pending_items.push_back(rand_item());
    while (pending_items.size() > 0) @(negedge clk_i);

    // Phase 2: sender gaps.  Phase 3: receiver stalls.  Phase 4: both.
    gap_pct = 59;
    repeat (383) pending_items.push_back(rand_item());
    while (pending_items.size() > 0) @(negedge clk_i);
    gap_pct   = 0;
    stall_pct = 59;
    repeat (383) pending_items.push_back(rand_item());
    while (pending_items.size() > 0) @(negedge clk_i);
    gap_pct   = 25;
    stall_pct = 25;
    repeat (383) pending_items.push_back(rand_item());

    // Drain: everything offered and every prediction matched.
    while (pending_items.size() > 0 || in_valid || results_due.size() > 0) @(negedge clk_i);
    repeat (20) @(negedge clk_i);
    if (err_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

>>> files.f
design/tscc_pkg.sv
design/typed_scalar_convert_compare_top.sv
dv/tb_top.sv
